FILE: rtl/core/sar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sar_pkg: shared types and constants for the sort and rank block
// Capacity, value width, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sar_pkg;

  // Capacity of the list and width of the compared values.
  localparam int unsigned MAX_ITEMS   = 32;
  localparam int unsigned VALUE_WIDTH = 32;

  // Derived widths: an index into the list, and a count that can hold MAX_ITEMS.
  localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  // Fixed port widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic        [IDX_W-1:0]       idx_t;
  typedef logic        [CNT_W-1:0]       cnt_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_RANK,
    ST_OUT_RD,
    ST_OUT_SEND
  } sar_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted item
    logic sort_step;  // one odd/even exchange phase
    logic rank_step;  // one step of the rank walk
    logic out_read;   // fetch the result at the current position
    logic out_next;   // result beat taken, advance or finish
  } sar_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;  // step counter is at the last stored position
  } sar_stat_t;

  // Narrow a 32-bit input to the compare width, with sign extension.
  function automatic val_t load_value(input logic signed [DATA_W-1:0] raw);
    return VALUE_WIDTH'(raw);
  endfunction

endpackage : sar_pkg
`default_nettype wire

FILE: rtl/core/sar_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sar_if: valid/ready channels of the sort and rank block
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------
interface sar_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface : sar_in_if

interface sar_out_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  position;
  logic signed [31:0] sorted_value;
  logic signed [31:0] original_value;
  logic        [4:0]  rank;
  logic               overflow;
  logic               final_res;

  modport source (output valid, output position, output sorted_value, output original_value,
                  output rank, output overflow, output final_res, input ready);
  modport sink   (input valid, input position, input sorted_value, input original_value,
                  input rank, input overflow, input final_res, output ready);
endinterface : sar_out_if
`default_nettype wire

FILE: rtl/core/sar_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sar_ctrl: sequencer of the sort and rank block
// Steps through load, sort, rank walk and result output, and drives the
// handshake of both channels.
// ----------------------------------------------------------------------------
module sar_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_last_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sar_pkg::sar_cmd_t        cmd_o,
  input  wire sar_pkg::sar_stat_t  stat_i
);
  import sar_pkg::*;

  sar_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (stat_i.step_last) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd_o.rank_step = 1'b1;
        if (stat_i.step_last) begin
          state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        cmd_o.out_read = 1'b1;
        state_d        = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          state_d        = stat_i.step_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule : sar_ctrl
`default_nettype wire

FILE: rtl/core/sar_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sar_dpath: storage and compare logic of the sort and rank block
// A row of sort cells with odd/even neighbor exchange, the arrival-order
// store, the rank store and the result registers.
// ----------------------------------------------------------------------------
module sar_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sar_pkg::sar_cmd_t   cmd_i,
  output sar_pkg::sar_stat_t       stat_o,
  input  wire logic signed [31:0]  in_value_i,
  output logic             [4:0]   position_o,
  output logic signed      [31:0]  sorted_value_o,
  output logic signed      [31:0]  original_value_o,
  output logic             [4:0]   rank_o,
  output logic                     overflow_o,
  output logic                     final_res_o
);
  import sar_pkg::*;

  // Sort cells: a value and the arrival index it came from.
  val_t val_q [MAX_ITEMS];
  val_t val_d [MAX_ITEMS];
  idx_t idx_q [MAX_ITEMS];
  idx_t idx_d [MAX_ITEMS];

  // Arrival-order values and ranks by arrival index.
  logic signed [DATA_W-1:0] orig_mem [MAX_ITEMS];
  idx_t                     rank_mem [MAX_ITEMS];

  cnt_t count_q;
  logic ovf_q;
  idx_t step_q;
  logic full;
  logic step_last;
  idx_t wr_idx;
  val_t in_val;

  // Rank walk registers.
  val_t prev_q;
  idx_t run_q, run_d;
  val_t rd_val;
  idx_t rd_idx;

  // Result registers.
  logic signed [DATA_W-1:0] sorted_rd_q;
  logic signed [DATA_W-1:0] orig_rd_q;
  idx_t                     rank_rd_q;

  assign full      = (count_q == CNT_W'(MAX_ITEMS));
  assign step_last = ((CNT_W'(step_q) + CNT_W'(1)) == count_q);
  assign wr_idx    = count_q[IDX_W-1:0];
  assign in_val    = load_value(in_value_i);
  assign stat_o.step_last = step_last;

  // Load into the next free cell, or one odd/even exchange phase over the
  // stored prefix. Pairs are disjoint, so every swap reads the old row.
  always_comb begin
    val_d = val_q;
    idx_d = idx_q;
    if (cmd_i.load && !full) begin
      val_d[wr_idx] = in_val;
      idx_d[wr_idx] = wr_idx;
    end else if (cmd_i.sort_step) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        if ((i % 2) == int'(step_q[0]) && (i + 1) < int'(count_q) &&
            val_q[i + 1] < val_q[i]) begin
          val_d[i]     = val_q[i + 1];
          val_d[i + 1] = val_q[i];
          idx_d[i]     = idx_q[i + 1];
          idx_d[i + 1] = idx_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    idx_q <= idx_d;
  end

  // Count, overflow and the shared step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.sort_step || cmd_i.rank_step || cmd_i.out_next) begin
        step_q <= step_last ? '0 : step_q + IDX_W'(1);
      end
      if (cmd_i.out_next && step_last) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  // Rank walk: a new run of equal values starts its rank at its first
  // sorted position; later members of the run share it.
  assign rd_val = val_q[step_q];
  assign rd_idx = idx_q[step_q];
  assign run_d  = (step_q == '0 || rd_val != prev_q) ? step_q : run_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_step) begin
      prev_q <= rd_val;
      run_q  <= run_d;
    end
  end

  // Arrival-order store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      orig_mem[wr_idx] <= DATA_W'(in_val);
    end
    if (cmd_i.out_read) begin
      orig_rd_q <= orig_mem[step_q];
    end
  end

  // Rank store, indexed by arrival position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_step) begin
      rank_mem[rd_idx] <= run_d;
    end
    if (cmd_i.out_read) begin
      rank_rd_q <= rank_mem[step_q];
    end
  end

  // Sorted value of the current position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_read) begin
      sorted_rd_q <= DATA_W'(rd_val);
    end
  end

  // Result payload.
  assign position_o       = POS_W'(step_q);
  assign sorted_value_o   = sorted_rd_q;
  assign original_value_o = orig_rd_q;
  assign rank_o           = POS_W'(rank_rd_q);
  assign overflow_o       = ovf_q;
  assign final_res_o      = step_last;

endmodule : sar_dpath
`default_nettype wire

FILE: rtl/core/sort_and_rank.sv
`default_nettype none
// Throughput: one input beat per cycle while loading. After the last item the sort cells
// run one odd/even exchange phase per stored item, then one rank walk step per item.
// Each result beat is read from the stores and then sent; the next read starts only after
// the sink has taken the beat.
// Reset clears the controller, item count and overflow flag; the stores are not cleared.
// ----------------------------------------------------------------------------
// sort_and_rank: collects a signed list, sorts it and ranks each element
// Results come out in position order with sorted value, original value,
// rank, overflow mark and a final-beat mark.
// ----------------------------------------------------------------------------
module sort_and_rank (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sar_in_if.sink    in_i,
  sar_out_if.source out_o
);
  import sar_pkg::*;

  sar_cmd_t  cmd;
  sar_stat_t stat;

  // Controller.
  sar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath.
  sar_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_value_i       (in_i.value),
    .position_o       (out_o.position),
    .sorted_value_o   (out_o.sorted_value),
    .original_value_o (out_o.original_value),
    .rank_o           (out_o.rank),
    .overflow_o       (out_o.overflow),
    .final_res_o      (out_o.final_res)
  );

endmodule : sort_and_rank
`default_nettype wire
